// ===== hw/rtl/tccw_pkg.sv =====
// Shared types and constants for the text console character writer.
package tccw_pkg;

    // Port widths of the transaction fields.
    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;
    localparam int COL_PW = 7;
    localparam int ROW_PW = 5;

    // Default console geometry.
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 32;

    // Control characters and the blank character.
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'd32;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_MOVE  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_COPY,
        ST_FILL
    } state_t;

endpackage

// ===== hw/rtl/text_console_char_writer.sv =====
// Text console character writer: character store, cursor and command sequencer.
//
// Usage: a command transaction (kind, char_in, col, row, last_row) is taken at a
// rising edge where start is high and busy is low. Every command produces one
// result: done is high for exactly one cycle with read_char, cursor_col and
// cursor_row valid. The receiver cannot stall; results must be taken at once.
//
// Throughput: character writes that do not scroll, cursor moves and cell reads
// raise done in the cycle after start, and busy stays low, so one such command
// can be issued every cycle. The store is a single-port-write, single-port-read
// memory of ROWS*COLUMNS bytes and the long commands walk it one cell per cycle:
//   clear rows:  blanks rows row through last_row (held to ROWS-1); if row is
//                past last_row, done comes with no walk,
//   scroll:      copies rows ROWS/2+2 to ROWS-2 up by one row, then blanks row
//                ROWS-2; taken by a write that lands on or is issued on the last row.
// busy is high while such a walk runs.
//
// Reset: the cursor goes to row 0, column 0, and a clearing pass writes zero to
// every cell with busy high.
module text_console_char_writer #(
    parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tccw_pkg::KIND_W-1:0]   kind,
    input  logic [tccw_pkg::CHAR_W-1:0]   char_in,
    input  logic [tccw_pkg::COL_PW-1:0]   col,
    input  logic [tccw_pkg::ROW_PW-1:0]   row,
    input  logic [tccw_pkg::ROW_PW-1:0]   last_row,
    output logic                          done,
    output logic [tccw_pkg::CHAR_W-1:0]   read_char,
    output logic [tccw_pkg::COL_PW-1:0]   cursor_col,
    output logic [tccw_pkg::ROW_PW-1:0]   cursor_row
);

    localparam int DEPTH  = ROWS * COLUMNS;
    localparam int MEM_AW = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    // Scroll region bounds.
    localparam int SCR_FIRST = ROWS / 2 + 1;
    localparam int SCR_LAST  = ROWS - 2;
    localparam bit HAS_COPY  = SCR_FIRST < SCR_LAST;
    localparam bit HAS_BLANK = SCR_FIRST <= SCR_LAST;

    logic [tccw_pkg::CHAR_W-1:0] mem [DEPTH];

    tccw_pkg::state_t            state_reg, state_next;
    logic [CNT_W-1:0]            addr_reg, addr_next;
    logic [CNT_W-1:0]            end_reg, end_next;
    logic                        cp_valid_reg, cp_valid_next;
    logic [MEM_AW-1:0]           cp_dst_reg, cp_dst_next;
    logic [COL_W-1:0]            cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]            cur_row_reg, cur_row_next;
    logic                        done_reg, done_next;
    logic                        read_sel_reg, read_sel_next;
    logic [tccw_pkg::CHAR_W-1:0] rdata_reg;

    logic                        we;
    logic [MEM_AW-1:0]           wa;
    logic [tccw_pkg::CHAR_W-1:0] wd;
    logic                        re;
    logic [MEM_AW-1:0]           ra;

    logic [CNT_W-1:0]            cur_addr;
    logic                        accept;
    logic                        adv;
    logic [COL_W-1:0]            wc_col;
    logic [ROW_W-1:0]            lr_sat;

    assign accept   = start && (state_reg == tccw_pkg::ST_IDLE);
    assign cur_addr = CNT_W'(int'(cur_row_reg) * COLUMNS) + CNT_W'(cur_col_reg);
    assign lr_sat   = (int'(last_row) >= ROWS) ? ROW_W'(ROWS - 1) : ROW_W'(last_row);

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        end_next      = end_reg;
        cp_valid_next = 1'b0;
        cp_dst_next   = cp_dst_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        done_next     = 1'b0;
        read_sel_next = 1'b0;
        we            = 1'b0;
        wa            = addr_reg[MEM_AW-1:0];
        wd            = tccw_pkg::CH_BLANK;
        re            = 1'b0;
        ra            = addr_reg[MEM_AW-1:0];
        adv           = 1'b0;
        wc_col        = cur_col_reg;

        unique case (state_reg)
            tccw_pkg::ST_INIT:
            begin
                we = 1'b1;
                wd = '0;
                if (addr_reg == CNT_W'(DEPTH - 1))
                begin
                    addr_next  = '0;
                    state_next = tccw_pkg::ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            tccw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (tccw_pkg::kind_t'(kind))
                        tccw_pkg::KIND_WRITE:
                        begin
                            if (char_in == tccw_pkg::CH_LF || char_in == tccw_pkg::CH_CR)
                            begin
                                wc_col = '0;
                                adv    = 1'b1;
                            end
                            else if (char_in == tccw_pkg::CH_BS ||
                                     char_in == tccw_pkg::CH_DEL)
                            begin
                                if (cur_col_reg != '0)
                                begin
                                    wc_col = cur_col_reg - 1'b1;
                                    we     = 1'b1;
                                    wa     = MEM_AW'(cur_addr - 1'b1);
                                    wd     = tccw_pkg::CH_BLANK;
                                end
                            end
                            else
                            begin
                                we = 1'b1;
                                wa = MEM_AW'(cur_addr);
                                wd = char_in;
                                if (int'(cur_col_reg) == COLUMNS - 1)
                                begin
                                    wc_col = '0;
                                    adv    = 1'b1;
                                end
                                else
                                begin
                                    wc_col = cur_col_reg + 1'b1;
                                end
                            end

                            // A write that lands on or is issued on the last row scrolls rows ROWS/2+1 to ROWS-2.
                            if ((adv && int'(cur_row_reg) >= ROWS - 2) ||
                                int'(cur_row_reg) >= ROWS - 1)
                            begin
                                cur_col_next = '0;
                                cur_row_next = ROW_W'(ROWS - 2);
                                if (HAS_COPY)
                                begin
                                    addr_next  = CNT_W'(SCR_FIRST * COLUMNS);
                                    end_next   = CNT_W'(SCR_LAST * COLUMNS);
                                    state_next = tccw_pkg::ST_COPY;
                                end
                                else if (HAS_BLANK)
                                begin
                                    addr_next  = CNT_W'(SCR_LAST * COLUMNS);
                                    end_next   = CNT_W'((SCR_LAST + 1) * COLUMNS);
                                    state_next = tccw_pkg::ST_FILL;
                                end
                                else
                                begin
                                    done_next = 1'b1;
                                end
                            end
                            else
                            begin
                                cur_col_next = wc_col;
                                cur_row_next = adv ? cur_row_reg + 1'b1 : cur_row_reg;
                                done_next    = 1'b1;
                            end
                        end

                        tccw_pkg::KIND_MOVE:
                        begin
                            cur_col_next = (int'(col) >= COLUMNS) ? COL_W'(COLUMNS - 1)
                                                                  : COL_W'(col);
                            cur_row_next = (int'(row) >= ROWS) ? ROW_W'(ROWS - 1)
                                                               : ROW_W'(row);
                            done_next    = 1'b1;
                        end

                        tccw_pkg::KIND_CLEAR:
                        begin
                            if (int'(row) > int'(lr_sat))
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                addr_next  = CNT_W'(int'(row) * COLUMNS);
                                end_next   = CNT_W'((int'(lr_sat) + 1) * COLUMNS);
                                state_next = tccw_pkg::ST_FILL;
                            end
                        end

                        tccw_pkg::KIND_READ:
                        begin
                            done_next = 1'b1;
                            if (int'(col) < COLUMNS && int'(row) < ROWS)
                            begin
                                re            = 1'b1;
                                ra            = MEM_AW'(int'(row) * COLUMNS + int'(col));
                                read_sel_next = 1'b1;
                            end
                        end

                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            tccw_pkg::ST_COPY:
            begin
                // Each cell is read one row below and written back in the next cycle.
                if (cp_valid_reg)
                begin
                    we = 1'b1;
                    wa = cp_dst_reg;
                    wd = rdata_reg;
                end
                if (addr_reg != end_reg)
                begin
                    re            = 1'b1;
                    ra            = MEM_AW'(addr_reg + CNT_W'(COLUMNS));
                    cp_valid_next = 1'b1;
                    cp_dst_next   = addr_reg[MEM_AW-1:0];
                    addr_next     = addr_reg + 1'b1;
                end
                else
                begin
                    end_next   = CNT_W'((SCR_LAST + 1) * COLUMNS);
                    state_next = tccw_pkg::ST_FILL;
                end
            end

            tccw_pkg::ST_FILL:
            begin
                we        = 1'b1;
                wd        = tccw_pkg::CH_BLANK;
                addr_next = addr_reg + 1'b1;
                if (addr_next == end_reg)
                begin
                    done_next  = 1'b1;
                    state_next = tccw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tccw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tccw_pkg::ST_INIT;
            addr_reg     <= '0;
            cp_valid_reg <= 1'b0;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            done_reg     <= 1'b0;
            read_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            cp_valid_reg <= cp_valid_next;
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            done_reg     <= done_next;
            read_sel_reg <= read_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg    <= end_next;
        cp_dst_reg <= cp_dst_next;
    end

    // Character store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rdata_reg <= mem[ra];
        end
    end

    assign busy       = (state_reg != tccw_pkg::ST_IDLE);
    assign done       = done_reg;
    assign read_char  = read_sel_reg ? rdata_reg : '0;
    assign cursor_col = tccw_pkg::COL_PW'(cur_col_reg);
    assign cursor_row = tccw_pkg::ROW_PW'(cur_row_reg);

endmodule
